### sv/arp_rr_pkg.sv
// ----------------------------------------------------------------------------
// arp_rr_pkg
// Constants shared by the ARP request responder and its checker.
// ----------------------------------------------------------------------------
package arp_rr_pkg;

  // Payload length of an Ethernet/IPv4 ARP frame, in bytes
  localparam int unsigned FRAME_BYTES  = 28;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned POS_W        = 5;

  // Byte positions that bound the captured fields
  localparam logic [POS_W-1:0] POS_LAST_HDR  = 5'd7;
  localparam logic [POS_W-1:0] POS_LAST_SMAC = 5'd13;
  localparam logic [POS_W-1:0] POS_LAST_SIP  = 5'd17;
  localparam logic [POS_W-1:0] POS_FIRST_TIP = 5'd24;
  localparam logic [POS_W-1:0] POS_FINAL     = 5'd27;
  localparam logic [POS_W-1:0] POS_DONE      = 5'd28;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_MAC = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_IP  = 1'b1;

  typedef logic [7:0] byte_t;

  // Expected request header: hw type 1, proto IPv4, hlen 6, plen 4, opcode 1
  localparam byte_t REQ_HEADER [HEADER_BYTES] = '{
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  // Reply header: same as the request but opcode 2
  localparam logic [63:0] REPLY_HEADER = 64'h0001_0800_0604_0002;

endpackage

### sv/arp_request_responder.sv
// ----------------------------------------------------------------------------
// arp_request_responder
// Parses received ARP payload bytes and answers requests for the local IP
// with a 28-byte ARP reply.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata          | tlast            | per beat
//  ----------+-----------+----------------+------------------+----------------
//  s_axis    | in        | [7:0] rx_byte  | rx_end           | one rx byte
//  m_axis    | out       | [7:0] tx_byte  | tx_last          | one reply byte
//  cfg       | in        | cfg_data 48b   | -                | one reg write
//
//  Each received byte updates the parse state straight from the input
//  beat. A matching 28th byte loads the whole reply into a shift register,
//  which then sends one byte per cycle while m_axis_tready is high, for 28 beats.
//  Receive keeps going during a reply; only a 28th byte of the next frame
//  waits until the reply shift register has emptied.
//  Reset (rst, synchronous) clears the parse position and the reply valid
//  and sets the header flag; output stalls simply hold the current byte.
// ----------------------------------------------------------------------------
module arp_request_responder (
  input  logic        clk,
  input  logic        rst,
  // receive stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,
  // reply stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [arp_rr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned REPLY_W = 8 * arp_rr_pkg::FRAME_BYTES;

  // configuration
  logic [47:0] local_mac;
  logic [31:0] local_ip;

  // parse state
  logic [arp_rr_pkg::POS_W-1:0] byte_position;
  logic                         header_matches;
  logic [47:0]                  peer_mac;
  logic [31:0]                  peer_ip;
  logic [31:0]                  asked_ip;

  // reply state
  logic                         busy;
  logic [arp_rr_pkg::POS_W-1:0] tx_count;
  logic [REPLY_W-1:0]           reply;

  logic        rx_beat;
  logic        tx_beat;
  logic        in_frame;
  logic        header_ok_next;
  logic [31:0] asked_ip_next;
  logic        reply_hit;

  // hold off only the byte that could start a second reply
  assign s_axis_tready = !(busy && byte_position == arp_rr_pkg::POS_FINAL);
  assign rx_beat       = s_axis_tvalid && s_axis_tready;
  assign tx_beat       = busy && m_axis_tready;
  assign in_frame      = byte_position < arp_rr_pkg::POS_DONE;

  // check the header byte and shift in the target IP
  always_comb begin
    header_ok_next = header_matches;
    if (byte_position <= arp_rr_pkg::POS_LAST_HDR &&
        s_axis_tdata != arp_rr_pkg::REQ_HEADER[byte_position[2:0]]) begin
      header_ok_next = 1'b0;
    end
    asked_ip_next = asked_ip;
    if (byte_position >= arp_rr_pkg::POS_FIRST_TIP && in_frame) begin
      asked_ip_next = {asked_ip[23:0], s_axis_tdata};
    end
  end

  assign reply_hit = rx_beat && byte_position == arp_rr_pkg::POS_FINAL &&
                     header_ok_next && asked_ip_next == local_ip;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_mac <= '0;
      local_ip  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arp_rr_pkg::REG_LOCAL_MAC: local_mac <= cfg_data;
        arp_rr_pkg::REG_LOCAL_IP:  local_ip  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // parse position and header flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_matches <= 1'b1;
    end else if (rx_beat) begin
      if (s_axis_tlast) begin
        byte_position  <= '0;
        header_matches <= 1'b1;
      end else if (in_frame) begin
        byte_position  <= byte_position + 1'b1;
        header_matches <= header_ok_next;
      end
    end
  end

  // capture sender addresses and target IP
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_mac <= '0;
      peer_ip  <= '0;
      asked_ip <= '0;
    end else if (rx_beat && in_frame) begin
      if (byte_position > arp_rr_pkg::POS_LAST_HDR &&
          byte_position <= arp_rr_pkg::POS_LAST_SMAC) begin
        peer_mac <= {peer_mac[39:0], s_axis_tdata};
      end else if (byte_position > arp_rr_pkg::POS_LAST_SMAC &&
                   byte_position <= arp_rr_pkg::POS_LAST_SIP) begin
        peer_ip <= {peer_ip[23:0], s_axis_tdata};
      end
      asked_ip <= asked_ip_next;
    end
  end

  // reply control: load on a hit, advance one byte per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      tx_count <= '0;
    end else if (reply_hit) begin
      busy     <= 1'b1;
      tx_count <= '0;
    end else if (tx_beat) begin
      if (tx_count == arp_rr_pkg::POS_FINAL) begin
        busy <= 1'b0;
      end
      tx_count <= tx_count + 1'b1;
    end
  end

  // reply bytes, first byte in the top lane
  always_ff @(posedge clk) begin
    if (reply_hit) begin
      reply <= {arp_rr_pkg::REPLY_HEADER, local_mac, asked_ip_next, peer_mac, peer_ip};
    end else if (tx_beat) begin
      reply <= {reply[REPLY_W-9:0], 8'h00};
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = reply[REPLY_W-1 -: 8];
  assign m_axis_tlast  = tx_count == arp_rr_pkg::POS_FINAL;

endmodule

### sv/arp_rr_checker.sv
// ----------------------------------------------------------------------------
// arp_rr_checker
// Port-level checks on the ARP request responder, bound into that module.
// ----------------------------------------------------------------------------
module arp_rr_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic [arp_rr_pkg::POS_W-1:0] beats;

  // count reply beats within the current reply
  always_ff @(posedge clk) begin
    if (rst) begin
      beats <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      beats <= m_axis_tlast ? '0 : beats + 1'b1;
    end
  end

  // a reply ends exactly on its 28th beat
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (beats == arp_rr_pkg::POS_FINAL)))
    else $error("reply tlast not on 28th beat");

  // receive is only held off while a reply is pending
  a_ready_low_busy: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("receive stalled without a pending reply");

  // a stalled reply byte holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("reply beat changed under stall");

  // no reply straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("reply valid after reset");

endmodule

bind arp_request_responder arp_rr_checker u_arp_rr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
